// ===== src/iee_pkg.sv =====
package iee_pkg;

  typedef enum logic [1:0] {
    TOK_NUM   = 2'd0,
    TOK_OPEN  = 2'd1,
    TOK_CLOSE = 2'd2,
    TOK_OPER  = 2'd3
  } tok_t;

  typedef enum logic [1:0] {
    AR_ADD = 2'd0,
    AR_SUB = 2'd1,
    AR_MUL = 2'd2,
    AR_DIV = 2'd3
  } arith_t;

  localparam logic [2:0] OPEN_CODE = 3'd4;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DIV0      = 3'd1,
    ST_UNMATCHED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_MALFORMED = 3'd4,
    ST_OVERFLOW  = 3'd5
  } status_t;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_TOKEN  = 9'b000000010,
    S_RDOP   = 9'b000000100,
    S_DECIDE = 9'b000001000,
    S_RDA    = 9'b000010000,
    S_EXEC   = 9'b000100000,
    S_DIV    = 9'b001000000,
    S_WB     = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  // why the reduction loop is running
  typedef enum logic [1:0] {
    M_CLOSE  = 2'd0,
    M_OPER   = 2'd1,
    M_FINISH = 2'd2
  } mode_t;

  function automatic logic [1:0] prio(input logic [2:0] code);
    if (code == 3'd0 || code == 3'd1) return 2'd1;
    if (code == 3'd2 || code == 3'd3) return 2'd2;
    return 2'd0;
  endfunction

endpackage

// ===== src/infix_expression_evaluator.sv =====
// channel | ports                                         | dir
// in      | in_valid in_ready in_op in_arith_code         | in
//         | in_number in_last                             |
// out     | out_valid out_ready out_result_value          | out
//         | out_status                                    |
// A token is accepted, then decoded; each stack decision adds a read wait, then a decide.
// A reduction adds an operand read, the ALU and a write back; a divide also runs the
// shared restoring divider, while a multiply is one product in the ALU state.
// The last token loads the out register and waits while a result is held.
// in_ready is high only in idle; a held result does not block new tokens.
// rst_n is synchronous; stack contents are not reset, only counts, error, state, mode and out_valid.
module infix_expression_evaluator import iee_pkg::*; #(
  parameter int STACK_DEPTH = 16,
  parameter int DATA_WIDTH  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_arith_code,
  input  logic signed [31:0] in_number,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic [2:0]         out_status
);

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DCW = $clog2(DATA_WIDTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  logic [DATA_WIDTH-1:0] opnd_mem [STACK_DEPTH];
  logic [2:0]            oper_mem [STACK_DEPTH];

  state_t state_r;
  mode_t  mode_r;
  logic [CW-1:0] ocnt_r, pcnt_r;
  status_t err_r;
  logic [1:0] tok_op_r, tok_code_r;
  logic [DATA_WIDTH-1:0] tok_num_r;
  logic tok_last_r;
  logic [2:0] top_r;
  logic [DATA_WIDTH-1:0] b_r, res_r;
  logic [DATA_WIDTH-1:0] rem_r, quo_r, dvs_r;
  logic [DCW-1:0] dcnt_r;
  logic neg_r;
  logic ov_r;
  logic [31:0] ores_r;
  logic [2:0] osta_r;

  // read ports (registered data)
  logic [DATA_WIDTH-1:0] rd_data;
  logic [2:0] op_rd_data;
  logic [AW-1:0] rd_addr;
  logic rd_sel_b;

  logic [DATA_WIDTH-1:0] mem_q;
  logic [2:0] opmem_q;

  always_comb begin
    rd_sel_b = (state_r == S_RDOP) || (state_r == S_TOKEN) ||
               (state_r == S_DECIDE) || (state_r == S_OUT);
    rd_addr  = rd_sel_b ? AW'(ocnt_r - CW'(1)) : AW'(ocnt_r - CW'(2));
  end

  always_ff @(posedge clk) begin
    mem_q   <= opnd_mem[rd_addr];
    opmem_q <= oper_mem[AW'(pcnt_r - CW'(1))];
  end
  assign rd_data = mem_q;
  assign op_rd_data = opmem_q;

  logic [DATA_WIDTH:0] dtrial;
  assign dtrial = {rem_r, quo_r[DATA_WIDTH-1]} - {1'b0, dvs_r};

  logic [DATA_WIDTH-1:0] abs_b;
  assign abs_b = b_r[DATA_WIDTH-1] ? (~b_r + 1'b1) : b_r;

  logic [DATA_WIDTH-1:0] num_ext;
  always_comb begin
    if (DATA_WIDTH >= 32) begin
      num_ext = DATA_WIDTH'($signed(tok_num_r[31:0]));
    end else begin
      num_ext = tok_num_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_result_value = ores_r;
  assign out_status = osta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ocnt_r  <= '0;
      pcnt_r  <= '0;
      err_r   <= ST_OK;
      ov_r    <= 1'b0;
      mode_r  <= M_CLOSE;
    end else begin
      if (ov_r && out_ready && state_r != S_OUT) begin
        ov_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            tok_op_r   <= in_op;
            tok_code_r <= in_arith_code;
            tok_num_r  <= DATA_WIDTH'(in_number);
            tok_last_r <= in_last;
            state_r    <= S_TOKEN;
          end
        end
        S_TOKEN: begin
          // operator stack top is valid in opmem_q now
          if (err_r != ST_OK) begin
            state_r <= tok_last_r ? S_OUT : S_IDLE;
          end else begin
            case (tok_op_r)
              TOK_NUM: begin
                if (ocnt_r >= FULL) begin
                  err_r <= ST_OVERFLOW;
                end else begin
                  opnd_mem[AW'(ocnt_r)] <= num_ext;
                  ocnt_r  <= ocnt_r + 1'b1;
                end
                mode_r  <= M_FINISH;
                state_r <= tok_last_r ? S_RDOP : S_IDLE;
              end
              TOK_OPEN: begin
                if (pcnt_r >= FULL) begin
                  err_r <= ST_OVERFLOW;
                end else begin
                  oper_mem[AW'(pcnt_r)] <= OPEN_CODE;
                  pcnt_r   <= pcnt_r + 1'b1;
                end
                mode_r  <= M_FINISH;
                state_r <= tok_last_r ? S_RDOP : S_IDLE;
              end
              TOK_CLOSE: begin
                if (pcnt_r == '0) begin
                  err_r   <= ST_UNMATCHED;
                  state_r <= tok_last_r ? S_OUT : S_IDLE;
                end else if (op_rd_data == OPEN_CODE) begin
                  err_r   <= ST_EMPTY;
                  state_r <= tok_last_r ? S_OUT : S_IDLE;
                end else begin
                  mode_r  <= M_CLOSE;
                  state_r <= S_RDOP;
                end
              end
              default: begin
                mode_r  <= M_OPER;
                state_r <= S_RDOP;
              end
            endcase
          end
        end
        S_RDOP: begin
          // wait for stack reads after pointer updates
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          top_r <= op_rd_data;
          b_r   <= rd_data;
          if (err_r != ST_OK) begin
            state_r <= tok_last_r ? S_OUT : S_IDLE;
          end else begin
            case (mode_r)
              M_CLOSE: begin
                if (pcnt_r == '0) begin
                  err_r   <= ST_UNMATCHED;
                  state_r <= tok_last_r ? S_OUT : S_IDLE;
                end else if (op_rd_data == OPEN_CODE) begin
                  pcnt_r  <= pcnt_r - 1'b1;
                  mode_r  <= M_FINISH;
                  state_r <= tok_last_r ? S_RDOP : S_IDLE;
                end else if (pcnt_r == CW'(1)) begin
                  pcnt_r  <= '0;
                  err_r   <= ST_UNMATCHED;
                  state_r <= tok_last_r ? S_OUT : S_IDLE;
                end else begin
                  pcnt_r  <= pcnt_r - 1'b1;
                  state_r <= S_RDA;
                end
              end
              M_OPER: begin
                if (pcnt_r != '0 && prio(op_rd_data) >= prio({1'b0, tok_code_r})) begin
                  pcnt_r  <= pcnt_r - 1'b1;
                  state_r <= S_RDA;
                end else begin
                  if (pcnt_r >= FULL) begin
                    err_r <= ST_OVERFLOW;
                  end else begin
                    oper_mem[AW'(pcnt_r)] <= {1'b0, tok_code_r};
                    pcnt_r   <= pcnt_r + 1'b1;
                  end
                  mode_r  <= M_FINISH;
                  state_r <= tok_last_r ? S_RDOP : S_IDLE;
                end
              end
              default: begin
                if (pcnt_r == '0) begin
                  if (ocnt_r != CW'(1)) begin
                    err_r <= ST_MALFORMED;
                  end
                  state_r <= S_OUT;
                end else if (op_rd_data == OPEN_CODE) begin
                  err_r   <= ST_MALFORMED;
                  state_r <= S_OUT;
                end else begin
                  pcnt_r  <= pcnt_r - 1'b1;
                  state_r <= S_RDA;
                end
              end
            endcase
          end
        end
        S_RDA: begin
          if (ocnt_r < CW'(2)) begin
            err_r   <= ST_MALFORMED;
            state_r <= tok_last_r ? S_OUT : S_IDLE;
          end else begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (arith_t'(top_r[1:0]))
            AR_ADD: begin
              res_r   <= rd_data + b_r;
              state_r <= S_WB;
            end
            AR_SUB: begin
              res_r   <= rd_data - b_r;
              state_r <= S_WB;
            end
            AR_MUL: begin
              res_r   <= DATA_WIDTH'(rd_data * b_r);
              state_r <= S_WB;
            end
            default: begin
              if (b_r == '0) begin
                err_r   <= ST_DIV0;
                state_r <= tok_last_r ? S_OUT : S_IDLE;
              end else begin
                state_r <= S_DIV;
                dcnt_r  <= '0;
                rem_r   <= '0;
                quo_r   <= rd_data[DATA_WIDTH-1] ? (~rd_data + 1'b1) : rd_data;
                dvs_r   <= abs_b;
                neg_r   <= rd_data[DATA_WIDTH-1] ^ b_r[DATA_WIDTH-1];
              end
            end
          endcase
        end
        S_DIV: begin
          if (dcnt_r == DCW'(DATA_WIDTH)) begin
            res_r   <= neg_r ? (~quo_r + 1'b1) : quo_r;
            state_r <= S_WB;
          end else begin
            dcnt_r <= dcnt_r + 1'b1;
            if (!dtrial[DATA_WIDTH]) begin
              rem_r <= dtrial[DATA_WIDTH-1:0];
              quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
              quo_r <= {quo_r[DATA_WIDTH-2:0], 1'b0};
            end
          end
        end
        S_WB: begin
          opnd_mem[AW'(ocnt_r - CW'(2))] <= res_r;
          ocnt_r  <= ocnt_r - 1'b1;
          state_r <= S_RDOP;
        end
        default: begin
          if (!ov_r || out_ready) begin
            ov_r    <= 1'b1;
            osta_r  <= err_r;
            ores_r  <= (err_r == ST_OK && ocnt_r == CW'(1)) ? 32'(rd_data) : '0;
            ocnt_r  <= '0;
            pcnt_r  <= '0;
            err_r   <= ST_OK;
            state_r <= S_IDLE;
          end
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) ocnt_r <= FULL)
    else $error("operand count past depth");
  assert property (@(posedge clk) disable iff (!rst_n) pcnt_r <= FULL)
    else $error("operator count past depth");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && (!ov_r || out_ready)) |=> ov_r && state_r == S_IDLE)
    else $error("result not loaded");
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> state_r == S_TOKEN)
    else $error("token not taken");
endmodule

// ===== verif/iee_checker.sv =====
module iee_checker import iee_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic [1:0]         in_arith_code,
  input  logic signed [31:0] in_number,
  input  logic               in_last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_result_value,
  input  logic [2:0]         out_status,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } expr_result_t;

  logic [31:0] vals[DEPTH];
  logic [2:0]  ops[DEPTH];
  int          nvals, nops;
  logic [2:0]  err;
  expr_result_t results_q[$];

  assign pending = results_q.size();

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic void flag(input logic [2:0] e);
    if (err == ST_OK) err = e;
  endfunction

  function automatic void push_val(input logic [31:0] v);
    if (nvals >= DEPTH) flag(ST_OVERFLOW);
    else begin
      vals[nvals] = v;
      nvals++;
    end
  endfunction

  function automatic void push_op(input logic [2:0] c);
    if (nops >= DEPTH) flag(ST_OVERFLOW);
    else begin
      ops[nops] = c;
      nops++;
    end
  endfunction

  function automatic void reduce(input logic [2:0] c);
    logic signed [31:0] a, b, r;
    logic [31:0] ua, ub, q;
    if (nvals < 2) begin
      flag(ST_MALFORMED);
      return;
    end
    b = vals[nvals-1];
    a = vals[nvals-2];
    case (arith_t'(c[1:0]))
      AR_ADD: r = a + b;
      AR_SUB: r = a - b;
      AR_MUL: r = a * b;
      default: begin
        if (b == 0) begin
          flag(ST_DIV0);
          return;
        end
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        q = ua / ub;
        r = (a[31] != b[31]) ? -q : q;
      end
    endcase
    nvals -= 2;
    vals[nvals] = r;
    nvals++;
  endfunction

  function automatic void take_token(input logic [1:0] op, input logic [1:0] code,
                                     input logic [31:0] num);
    logic [2:0] top;
    case (tok_t'(op))
      TOK_NUM: push_val(num);
      TOK_OPEN: push_op(OPEN_CODE);
      TOK_CLOSE: begin
        if (nops == 0) begin
          flag(ST_UNMATCHED);
          return;
        end
        if (ops[nops-1] == OPEN_CODE) begin
          flag(ST_EMPTY);
          return;
        end
        while (err == ST_OK) begin
          if (nops == 0) begin
            flag(ST_UNMATCHED);
            return;
          end
          top = ops[nops-1];
          nops--;
          if (top == OPEN_CODE) return;
          if (nops == 0) begin
            flag(ST_UNMATCHED);
            return;
          end
          reduce(top);
        end
      end
      default: begin
        while (err == ST_OK && nops > 0) begin
          top = ops[nops-1];
          if (prio(top) < prio({1'b0, code})) break;
          nops--;
          reduce(top);
        end
        if (err == ST_OK) push_op({1'b0, code});
      end
    endcase
  endfunction

  function automatic void close_expr();
    logic [2:0] top;
    expr_result_t res;
    while (err == ST_OK && nops > 0) begin
      top = ops[nops-1];
      if (top == OPEN_CODE) begin
        flag(ST_MALFORMED);
        break;
      end
      nops--;
      reduce(top);
    end
    if (err == ST_OK && nvals != 1) flag(ST_MALFORMED);
    res.value = (err == ST_OK) ? vals[0] : 32'd0;
    res.status = err;
    results_q = {results_q, res};
    nvals = 0;
    nops = 0;
    err = ST_OK;
  endfunction

  always @(posedge clk) begin
    expr_result_t exp_r;
    if (!rst_n) begin
      nvals = 0;
      nops = 0;
      err = ST_OK;
      results_q.delete();
      fail_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (err == ST_OK) take_token(in_op, in_arith_code, in_number);
        if (in_last) close_expr();
      end
      if (out_valid && out_ready) begin
        if (results_q.size() == 0) report("result with no request pending");
        else begin
          exp_r = results_q.pop_front();
          if (out_result_value !== exp_r.value)
            report($sformatf("value %0d, expected %0d", out_result_value,
                             $signed(exp_r.value)));
          if (out_status !== exp_r.status)
            report($sformatf("status %0d, expected %0d", out_status, exp_r.status));
        end
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
module testbench import iee_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         in_op = '0;
  logic [1:0]         in_arith_code = '0;
  logic signed [31:0] in_number = '0;
  logic               in_last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic [2:0]         out_status;
  int                 fail_count, pending;
  int                 send_idle = 0, recv_idle = 0;
  int                 cycles = 0;

  typedef struct {
    logic [1:0]  op;
    logic [1:0]  code;
    logic [31:0] num;
    logic        last;
  } token_t;
  token_t tokens_q[$];

  always #2 clk = ~clk;

  infix_expression_evaluator u_dut (.*);

  iee_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  function automatic logic [31:0] rand_num();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return $urandom();
      3: return -$urandom_range(4);
      default: return $urandom_range(20);
    endcase
  endfunction

  function automatic void tok(input tok_t op, input logic [1:0] code,
                              input logic [31:0] num, input logic last);
    token_t t;
    t.op = op; t.code = code; t.num = num; t.last = last;
    tokens_q = {tokens_q, t};
  endfunction

  // well-formed expression: operand (op operand)*, with random nesting
  function automatic void operand(input int lvl);
    if (lvl < 3 && $urandom_range(3) == 0) begin
      tok(TOK_OPEN, 2'($urandom()), $urandom(), 0);
      expr(lvl + 1);
      tok(TOK_CLOSE, 2'($urandom()), $urandom(), 0);
    end else
      tok(TOK_NUM, 2'($urandom()), rand_num(), 0);
  endfunction

  function automatic void expr(input int lvl);
    int n;
    n = $urandom_range(3);
    operand(lvl);
    repeat (n) begin
      tok(TOK_OPER, 2'($urandom()), $urandom(), 0);
      operand(lvl);
    end
  endfunction

  task automatic send_all();
    token_t t;
    while (tokens_q.size() > 0) begin
      t = tokens_q.pop_front();
      in_valid <= 1'b1;
      in_op <= t.op;
      in_arith_code <= t.code;
      in_number <= t.num;
      in_last <= t.last;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      if (tokens_q.size() == 0 || $urandom_range(99) < send_idle) begin
        in_valid <= 1'b0;
        @(negedge clk);
        while ($urandom_range(99) < send_idle) @(negedge clk);
      end
    end
  endtask

  task automatic random_phase(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) < 8) begin
        expr(0);
        tokens_q[$].last = 1'b1;
      end else begin
        repeat ($urandom_range(1, 6))
          tok(tok_t'($urandom_range(3)), 2'($urandom()), rand_num(), 0);
        tok(tok_t'($urandom_range(3)), 2'($urandom()), rand_num(), 1);
      end
      sent += tokens_q.size();
      send_all();
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    send_idle = 24; recv_idle = 61;
    // 7 - 3 * 2 / (1 + 1) = 4
    tok(TOK_NUM, 0, 7, 0); tok(TOK_OPER, AR_SUB, 0, 0); tok(TOK_NUM, 0, 3, 0);
    tok(TOK_OPER, AR_MUL, 0, 0); tok(TOK_NUM, 0, 2, 0);
    tok(TOK_OPER, AR_DIV, 0, 0); tok(TOK_OPEN, 0, 0, 0); tok(TOK_NUM, 0, 1, 0);
    tok(TOK_OPER, AR_ADD, 0, 0); tok(TOK_NUM, 0, 1, 0); tok(TOK_CLOSE, 0, 0, 1);
    // most negative / -1
    tok(TOK_NUM, 0, 32'h80000000, 0); tok(TOK_OPER, AR_DIV, 0, 0);
    tok(TOK_NUM, 0, 32'hffffffff, 1);
    // divide by zero
    tok(TOK_NUM, 0, 32'h7fffffff, 0); tok(TOK_OPER, AR_DIV, 0, 0);
    tok(TOK_NUM, 0, 0, 1);
    tok(TOK_CLOSE, 3, 32'hffffffff, 1);
    tok(TOK_OPEN, 0, 0, 0); tok(TOK_CLOSE, 0, 0, 1);
    tok(TOK_OPEN, 0, 0, 0); tok(TOK_NUM, 0, 5, 1);
    tok(TOK_OPER, AR_ADD, 0, 1);
    tok(TOK_NUM, 0, 1, 0); tok(TOK_NUM, 0, 2, 1);
    send_all();
    repeat (17) tok(TOK_NUM, 0, 1, 0);
    tok(TOK_NUM, 0, 1, 1);
    repeat (17) tok(TOK_OPEN, 0, 0, 0);
    tok(TOK_OPEN, 0, 0, 1);
    send_all();
    random_phase(230);
    send_idle = 61; recv_idle = 24;
    random_phase(230);
    send_idle = 0; recv_idle = 0;
    random_phase(230);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

// ===== sim.f =====
src/iee_pkg.sv
src/infix_expression_evaluator.sv
verif/iee_checker.sv
verif/testbench.sv
